// ===== rtl/core/fvn_pkg.sv =====
// ============================================================================
// fvn_pkg
// Shared types, constants and elaboration-time functions for the fractal
// value-noise height block.
// ============================================================================
`default_nettype none

package fvn_pkg;

  // Width of the running octave sum. The sum stays below four times the
  // amplitude total, which is under 2^34 for up to sixteen octaves.
  localparam int SUM_W = 34;

  localparam logic [15:0] RELIEF_RESET = 16'd1000;

  // Per-axis multipliers of the lattice hash, index 0 is x.
  localparam logic [2:0][31:0] AXIS_MUL = {32'hCB1AB31F, 32'hD8163841, 32'h8DA6B343};
  localparam logic [31:0] MIX_MUL_A = 32'h2C1B3C6D;
  localparam logic [31:0] MIX_MUL_B = 32'h297A2D39;
  localparam logic [31:0] HASH_ALL_ONES = 32'hFFFFFFFF;

  // Direction handed from one octave cell to the next.
  typedef struct packed {
    logic             valid;
    logic [2:0][31:0] mag;
    logic [2:0]       neg;
  } dir_bus_t;

  // Octave frequency in Q.32: 32, then times 2.6 per octave.
  function automatic logic [63:0] octave_freq(input int k);
    logic [63:0] f;
    f = 64'd32 << 32;
    for (int i = 0; i < k; i++) begin
      f = (f * 64'd13 + 64'd2) / 64'd5;
    end
    return f;
  endfunction

  // Octave amplitude in Q.30: 1.0, then times 0.72 per octave.
  function automatic logic [63:0] octave_amp(input int k);
    logic [63:0] a;
    a = 64'd1 << 30;
    for (int i = 0; i < k; i++) begin
      a = (a * 64'd18 + 64'd12) / 64'd25;
    end
    return a;
  endfunction

  // Total of the amplitudes over n octaves.
  function automatic logic [63:0] norm_sum(input int n);
    logic [63:0] s;
    s = 64'd0;
    for (int i = 0; i < n; i++) begin
      s = s + octave_amp(i);
    end
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/fvn_if.sv =====
// ============================================================================
// fvn_if
// Valid/ready channels of the fractal value-noise height block.
// ============================================================================
`default_nettype none

interface fvn_dir_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] dir_x;
  logic signed [31:0] dir_y;
  logic signed [31:0] dir_z;
  modport source (output valid, output dir_x, output dir_y, output dir_z, input ready);
  modport sink (input valid, input dir_x, input dir_y, input dir_z, output ready);
endinterface

interface fvn_height_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] height_out;
  modport source (output valid, output height_out, input ready);
  modport sink (input valid, input height_out, output ready);
endinterface

interface fvn_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] relief_range;
  modport source (output valid, output relief_range, input ready);
  modport sink (input valid, input relief_range, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/fractal_value_noise_height.sv =====
// ============================================================================
// fractal_value_noise_height
// Terrain height from a unit direction by fractal 3-D value noise.
// ============================================================================
// A direction item (dir_x, dir_y, dir_z, signed Q2.30) enters on the sample
// channel; one height item (metres times 65536, saturated) leaves on the
// result channel for every direction taken, in the same order.
// The relief span is written through the cfg channel, which is always ready;
// write it only while no item is in flight. Reset sets it to 1000 metres.
// Throughput is one item per cycle while the output queue has room. Each
// octave is one cell of a chain: the direction passes one register in each
// cell while each cell works through its own thirteen-stage pipeline, and the
// running sum follows the same skew. A result passes through the cell
// pipelines and four output stages before it is offered.
// A two-entry output queue sits in front of the result channel. While it
// holds a waiting result the chain keeps taking items; only when both
// entries are full does the whole chain hold and sample.ready drop.
// Reset empties the pipeline and the queue; no result is offered after it
// until a new item has passed through.
// ============================================================================
`default_nettype none

module fractal_value_noise_height #(
  parameter int OCTAVE_COUNT      = 10,
  parameter int LATTICE_FRAC_BITS = 16
) (
  input wire logic    clk,
  input wire logic    rst,
  fvn_cfg_if.sink     cfg,
  fvn_dir_if.sink     sample,
  fvn_height_if.source result
);

  localparam int FRAC_BITS = (LATTICE_FRAC_BITS < 8)  ? 8  :
                             (LATTICE_FRAC_BITS > 24) ? 24 : LATTICE_FRAC_BITS;

  logic [15:0] relief;
  logic        adv;

  // Relief register; the configuration channel never stalls.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      relief <= fvn_pkg::RELIEF_RESET;
    end else if (cfg.valid) begin
      relief <= cfg.relief_range;
    end
  end

  // Split each axis into sign and magnitude; the most negative code gives
  // a magnitude of exactly two, which still fits the 32-bit magnitude.
  fvn_pkg::dir_bus_t dir_head;
  logic [2:0][31:0]  raw;

  always_comb begin
    raw[0] = sample.dir_x;
    raw[1] = sample.dir_y;
    raw[2] = sample.dir_z;
    dir_head.valid = sample.valid;
    for (int i = 0; i < 3; i++) begin
      dir_head.neg[i] = raw[i][31];
      dir_head.mag[i] = raw[i][31] ? (~raw[i] + 32'd1) : raw[i];
    end
  end

  assign sample.ready = adv;

  // Chain of octave cells. Cell k passes the direction on through a single
  // register and hands its partial sum to cell k+1 exactly when that cell's own
  // octave term is ready.
  fvn_pkg::dir_bus_t         dir_link [OCTAVE_COUNT+1];
  logic [fvn_pkg::SUM_W-1:0] sum_link [OCTAVE_COUNT+1];
  logic [OCTAVE_COUNT-1:0]   sum_vld;

  assign dir_link[0] = dir_head;
  assign sum_link[0] = '0;

  genvar k;
  generate
    for (k = 0; k < OCTAVE_COUNT; k++) begin : g_oct
      fvn_octave_cell #(
        .OCT       (k),
        .FRAC_BITS (FRAC_BITS)
      ) u_cell (
        .clk       (clk),
        .rst       (rst),
        .adv       (adv),
        .dir_in    (dir_link[k]),
        .dir_out   (dir_link[k+1]),
        .sum_in    (sum_link[k]),
        .sum_out   (sum_link[k+1]),
        .sum_valid (sum_vld[k])
      );
    end
  endgenerate

  // Normalisation, relief scaling and the output queue.
  fvn_out_stage #(
    .OCTAVE_COUNT (OCTAVE_COUNT)
  ) u_out (
    .clk        (clk),
    .rst        (rst),
    .sum_in     (sum_link[OCTAVE_COUNT]),
    .sum_valid  (sum_vld[OCTAVE_COUNT-1]),
    .relief     (relief),
    .res_ready  (result.ready),
    .adv        (adv),
    .res_valid  (result.valid),
    .res_height (result.height_out)
  );

endmodule

`default_nettype wire

// ===== rtl/core/fvn_octave_cell.sv =====
// ============================================================================
// fvn_octave_cell
// One octave of value noise: lattice split, smoothstep, corner hash,
// trilinear blend, amplitude weighting and accumulation into the sum.
// ============================================================================
`default_nettype none

module fvn_octave_cell #(
  parameter int OCT       = 0,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      adv,
  input  wire fvn_pkg::dir_bus_t         dir_in,
  output      fvn_pkg::dir_bus_t         dir_out,
  input  wire logic [fvn_pkg::SUM_W-1:0] sum_in,
  output      logic [fvn_pkg::SUM_W-1:0] sum_out,
  output      logic                      sum_valid
);

  localparam int STAGES = 13;
  localparam int PW     = FRAC_BITS + 32;
  localparam int SH     = 30 - FRAC_BITS;
  localparam logic [63:0] FREQ = fvn_pkg::octave_freq(OCT);
  localparam logic [63:0] AMP_FULL = fvn_pkg::octave_amp(OCT);
  localparam logic [31:0] FLO = FREQ[31:0];
  localparam logic [31:0] FHI = FREQ[63:32];
  localparam logic [30:0] AMP = AMP_FULL[30:0];
  localparam logic [33:0] SMOOTH_K = 34'd196608;

  function automatic logic [32:0] blend(input logic [32:0] a, input logic [32:0] b,
                                        input logic [15:0] s);
    logic [49:0] pa;
    logic [49:0] pb;
    logic [50:0] acc;
    pa  = 50'(a) * 50'(17'h10000 - 17'(s));
    pb  = 50'(b) * 50'(s);
    acc = 51'(pa) + 51'(pb);
    return acc[48:16];
  endfunction

  logic [STAGES-1:0] vld;

  logic [2:0][31:0]    mag_s1;
  logic [2:0]          neg_s1;
  logic [2:0][63:0]    lo_s2;
  logic [2:0][63:0]    hi_s2;
  logic [2:0]          neg_s2;
  logic [2:0][PW-1:0]  q_s3;
  logic [2:0]          rem_s3;
  logic [2:0]          neg_s3;
  logic [2:0][31:0]    cell_s4;
  logic [2:0][15:0]    t_s4;
  logic [2:0][15:0]    t_s5;
  logic [2:0][15:0]    t2_s5;
  logic [2:0][1:0][31:0] hm_s5;
  logic [2:0][15:0]    s_s6;
  logic [7:0][31:0]    hk_s6;
  logic [2:0][15:0]    s_s7;
  logic [7:0][31:0]    hk_s7;
  logic [2:0][15:0]    s_s8;
  logic [7:0][32:0]    cv_s8;
  logic [2:0][15:0]    s_s9;
  logic [3:0][32:0]    bx_s9;
  logic [2:0][15:0]    s_s10;
  logic [1:0][32:0]    by_s10;
  logic [32:0]         n_s11;
  logic [fvn_pkg::SUM_W-1:0] term_s12;

  logic [2:0][63:0]    mid_c;
  logic [2:0][PW-1:0]  p_c;
  logic [2:0][15:0]    t_c;
  logic [7:0][31:0]    hx_c;
  logic [7:0][31:0]    hy_c;
  logic [7:0][31:0]    hz_c;
  logic [63:0]         wt_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[STAGES-2:0], dir_in.valid};
    end
  end

  assign dir_out   = '{valid: vld[0], mag: mag_s1, neg: neg_s1};
  assign sum_valid = vld[STAGES-1];

  // A negative axis rounds its lattice position toward minus infinity, so a
  // nonzero remainder bumps the magnitude before negation; a positive axis
  // simply truncates.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mid_c[i] = (lo_s2[i] >> 32) + hi_s2[i];
      p_c[i]   = neg_s3[i] ? (PW'(0) - (q_s3[i] + PW'(rem_s3[i])))
                           : q_s3[i];
    end
    for (int j = 0; j < 8; j++) begin
      hx_c[j] = hm_s5[0][j[0]] ^ hm_s5[1][j[1]] ^ hm_s5[2][j[2]];
      hx_c[j] = hx_c[j] ^ (hx_c[j] >> 15);
      hy_c[j] = hk_s6[j] ^ (hk_s6[j] >> 12);
      hz_c[j] = hk_s7[j] ^ (hk_s7[j] >> 15);
    end
    wt_c = 64'(AMP) * 64'(n_s11);
  end

  // Fraction brought to Q.16 from the configured lattice precision.
  generate
    if (FRAC_BITS >= 16) begin : g_frac_down
      always_comb begin
        for (int i = 0; i < 3; i++) begin
          t_c[i] = p_c[i][FRAC_BITS-1 -: 16];
        end
      end
    end else begin : g_frac_up
      always_comb begin
        for (int i = 0; i < 3; i++) begin
          t_c[i] = {p_c[i][FRAC_BITS-1:0], {(16-FRAC_BITS){1'b0}}};
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (adv) begin
      mag_s1 <= dir_in.mag;
      neg_s1 <= dir_in.neg;
      neg_s2 <= neg_s1;
      neg_s3 <= neg_s2;
      for (int i = 0; i < 3; i++) begin
        lo_s2[i]   <= 64'(mag_s1[i]) * 64'(FLO);
        hi_s2[i]   <= 64'(mag_s1[i]) * 64'(FHI);
        q_s3[i]    <= mid_c[i][SH +: PW];
        rem_s3[i]  <= (lo_s2[i][31:0] != 32'd0) || (mid_c[i][SH-1:0] != '0);
        cell_s4[i] <= p_c[i][PW-1:FRAC_BITS];
        t_s4[i]    <= t_c[i];
        t_s5[i]    <= t_s4[i];
        t2_s5[i]   <= 16'((32'(t_s4[i]) * 32'(t_s4[i])) >> 16);
        s_s6[i]    <= 16'((34'(t2_s5[i]) * (SMOOTH_K - 34'({t_s5[i], 1'b0}))) >> 16);
        for (int b = 0; b < 2; b++) begin
          hm_s5[i][b] <= (cell_s4[i] + 32'(b)) * fvn_pkg::AXIS_MUL[i];
        end
      end
      for (int j = 0; j < 8; j++) begin
        hk_s6[j] <= hx_c[j] * fvn_pkg::MIX_MUL_A;
        hk_s7[j] <= hy_c[j] * fvn_pkg::MIX_MUL_B;
        cv_s8[j] <= 33'(hz_c[j]) + 33'(hz_c[j] == fvn_pkg::HASH_ALL_ONES);
      end
      s_s7  <= s_s6;
      s_s8  <= s_s7;
      s_s9  <= s_s8;
      s_s10 <= s_s9;
      for (int p = 0; p < 4; p++) begin
        bx_s9[p] <= blend(cv_s8[2*p], cv_s8[2*p+1], s_s8[0]);
      end
      for (int q = 0; q < 2; q++) begin
        by_s10[q] <= blend(bx_s9[2*q], bx_s9[2*q+1], s_s9[1]);
      end
      n_s11    <= blend(by_s10[0], by_s10[1], s_s10[2]);
      term_s12 <= wt_c[30 +: fvn_pkg::SUM_W];
      sum_out  <= sum_in + term_s12;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/fvn_out_stage.sv =====
// ============================================================================
// fvn_out_stage
// Normalises the octave sum, applies the relief scale with saturation and
// buffers finished heights in a two-entry output queue.
// ============================================================================
`default_nettype none

module fvn_out_stage #(
  parameter int OCTAVE_COUNT = 10
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic [fvn_pkg::SUM_W-1:0] sum_in,
  input  wire logic                      sum_valid,
  input  wire logic [15:0]               relief,
  input  wire logic                      res_ready,
  output      logic                      adv,
  output      logic                      res_valid,
  output      logic signed [31:0]        res_height
);

  localparam logic [63:0] NORM = fvn_pkg::norm_sum(OCTAVE_COUNT);
  localparam logic [63:0] RECIP_FULL =
    (NORM == 64'd0) ? 64'd0 : (64'd1 << 60) / ((NORM == 64'd0) ? 64'd1 : NORM);
  localparam logic [30:0] RECIP = RECIP_FULL[30:0];
  localparam int HI_W = fvn_pkg::SUM_W - 32;
  localparam logic [1:0] FIFO_DEPTH = 2'd2;
  localparam logic signed [34:0] H_MAX = 35'sd2147483647;
  localparam logic signed [34:0] H_MIN = -35'sd2147483648;

  logic [2:0]         vld;
  logic [63:0]        pl_o1;
  logic [HI_W+30:0]   ph_o1;
  logic signed [33:0] u_o2;
  logic signed [50:0] prod_o3;

  logic [65:0]        full_c;
  logic signed [34:0] hs_c;
  logic signed [31:0] sat_c;

  logic [1:0][31:0]   fifo_q;
  logic               wr_ptr;
  logic               rd_ptr;
  logic [1:0]         count;
  logic               push;
  logic               pop;

  assign adv  = (count != FIFO_DEPTH);
  assign push = adv && vld[2];
  assign pop  = res_valid && res_ready;

  always_comb begin
    full_c = 66'(pl_o1) + (66'(ph_o1) << 32);
    hs_c   = prod_o3[50:16];
    if (hs_c > H_MAX) begin
      sat_c = 32'(H_MAX);
    end else if (hs_c < H_MIN) begin
      sat_c = 32'(H_MIN);
    end else begin
      sat_c = hs_c[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[1:0], sum_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pl_o1   <= 64'(sum_in[31:0]) * 64'(RECIP);
      ph_o1   <= (HI_W+31)'(sum_in[fvn_pkg::SUM_W-1:32]) * (HI_W+31)'(RECIP);
      u_o2    <= $signed({1'b0, full_c[62:30]}) - 34'sd2147483648;
      prod_o3 <= 51'(u_o2) * 51'($signed({1'b0, relief}));
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_q[wr_ptr] <= sat_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  assign res_valid  = (count != 2'd0);
  assign res_height = fifo_q[rd_ptr];

endmodule

`default_nettype wire

// ===== tb/sv/fractal_value_noise_height_test.sv =====
// ----------------------------------------------------------------------------
// Fractal value-noise height testbench
// Drives direction items into the height block and checks every height item
// against a bit-exact fixed-point predictor of the ten-octave noise sum. The
// relief span is rewritten between phases, and both channels idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module fractal_value_noise_height_test;

  // Size of the design under test, which is built with its default values.
  localparam int OCTAVES   = 10;
  localparam int LAT_BITS  = 16;
  // Cycles allowed after the last height item before ending or writing relief.
  localparam int SETTLE    = 40;
  // Hard end of the run, far beyond the slowest correct run.
  localparam int MAX_CYCLES = 400000;
  localparam int RAND_PER_PHASE = 390;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } dir_t;

  logic clk;
  logic rst;

  fvn_cfg_if    cfg_ch();
  fvn_dir_if    dir_ch();
  fvn_height_if height_ch();

  fractal_value_noise_height u_top (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .sample (dir_ch),
    .result (height_ch)
  );

  // The testbench copy of the relief span register.
  logic [15:0] relief_now;

  // Heights still owed by the block, oldest first.
  logic signed [31:0] height_queue[$];

  int unsigned cycle_count;
  int unsigned mismatch_count;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  // Directed directions: zero, the unit axes in both signs, the ends of the
  // Q2.30 range (including -2.0 and patterns beyond unit length), the
  // smallest steps on each side of zero and a few lattice-edge fractions.
  localparam int DIR_ROWS = 18;
  localparam dir_t DIR_TABLE [DIR_ROWS] = '{
    '{32'sh00000000, 32'sh00000000, 32'sh00000000},
    '{32'sh40000000, 32'sh00000000, 32'sh00000000},
    '{32'sh00000000, 32'sh40000000, 32'sh00000000},
    '{32'sh00000000, 32'sh00000000, 32'sh40000000},
    '{32'shC0000000, 32'sh00000000, 32'sh00000000},
    '{32'sh00000000, 32'shC0000000, 32'sh00000000},
    '{32'sh00000000, 32'sh00000000, 32'shC0000000},
    '{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF},
    '{32'sh80000000, 32'sh80000000, 32'sh80000000},
    '{32'sh80000000, 32'sh7FFFFFFF, 32'sh00000000},
    '{32'sh00000001, 32'shFFFFFFFF, 32'sh00000001},
    '{32'shFFFFFFFF, 32'shFFFFFFFF, 32'shFFFFFFFF},
    '{32'sh24F3C5A1, 32'sh24F3C5A1, 32'sh24F3C5A1},
    '{32'shDB0C3A5F, 32'sh24F3C5A1, 32'shDB0C3A5F},
    '{32'sh00020000, 32'shFFFE0000, 32'sh00040000},
    '{32'sh55555555, 32'shAAAAAAAA, 32'sh12345678},
    '{32'sh3FFFFFFF, 32'shC0000001, 32'sh00000000},
    '{32'sh2D413CCD, 32'sh2D413CCD, 32'sh00000000}
  };

  // Corner value of one lattice point: the mix hash, with all ones nudged up
  // so that the value spans [0, 2^32] in Q.32.
  function automatic logic [63:0] lattice_corner(logic [31:0] cx, logic [31:0] cy,
                                                 logic [31:0] cz);
    logic [31:0] h;
    h = (cx * fvn_pkg::AXIS_MUL[0]) ^ (cy * fvn_pkg::AXIS_MUL[1]) ^
        (cz * fvn_pkg::AXIS_MUL[2]);
    h = h ^ (h >> 15);
    h = h * fvn_pkg::MIX_MUL_A;
    h = h ^ (h >> 12);
    h = h * fvn_pkg::MIX_MUL_B;
    h = h ^ (h >> 15);
    return {32'd0, h} + ((h == fvn_pkg::HASH_ALL_ONES) ? 64'd1 : 64'd0);
  endfunction

  function automatic logic [63:0] lerp16(logic [63:0] a, logic [63:0] b, logic [63:0] s);
    return (a * (64'd65536 - s) + b * s) >> 16;
  endfunction

  function automatic logic [63:0] smoothstep16(logic [63:0] t);
    logic [63:0] t2;
    t2 = (t * t) >> 16;
    return (t2 * (64'd196608 - 2 * t)) >> 16;
  endfunction

  // Splits magnitude times frequency into a wrapped cell index and a Q.16
  // fraction. Negative axes round the cell toward minus infinity.
  function automatic void cell_split(logic [63:0] mag, logic neg, logic [63:0] freq,
                                     output logic [31:0] cell_idx, output logic [63:0] t16);
    logic [63:0] lo, mid, q, m, frac, mask;
    logic rem;
    int sh;
    sh = 62 - LAT_BITS - 32;
    mask = (64'd1 << LAT_BITS) - 1;
    lo = mag * {32'd0, freq[31:0]};
    mid = (lo >> 32) + mag * {32'd0, freq[63:32]};
    q = mid >> sh;
    if (!neg) begin
      cell_idx = q[LAT_BITS +: 32];
      frac = q & mask;
    end else begin
      rem = (lo[31:0] != 0) || ((mid & ((64'd1 << sh) - 1)) != 0);
      m = q + (rem ? 64'd1 : 64'd0);
      cell_idx = 32'd0 - 32'((m + mask) >> LAT_BITS);
      frac = (64'd0 - m) & mask;
    end
    t16 = (LAT_BITS >= 16) ? (frac >> (LAT_BITS - 16)) : (frac << (16 - LAT_BITS));
  endfunction

  // Height in metres times 65536 for one direction at the current relief.
  function automatic logic signed [31:0] terrain_height(dir_t d, logic [15:0] relief);
    logic [63:0] mag[3], smooth[3], t, freq, amp, octave_sum, norm, recip, v, y0, y1;
    logic [63:0] zl[2], noise;
    logic [31:0] lat_cell[3], cz;
    logic neg[3];
    logic [31:0] raw[3];
    longint signed u, prod, h;
    raw[0] = d.x;
    raw[1] = d.y;
    raw[2] = d.z;
    for (int i = 0; i < 3; i++) begin
      neg[i] = raw[i][31];
      mag[i] = neg[i] ? ((64'd1 << 32) - {32'd0, raw[i]}) : {32'd0, raw[i]};
    end
    freq = 64'd32 << 32;
    amp = 64'd1 << 30;
    octave_sum = 0;
    norm = 0;
    for (int k = 0; k < OCTAVES; k++) begin
      for (int i = 0; i < 3; i++) begin
        cell_split(mag[i], neg[i], freq, lat_cell[i], t);
        smooth[i] = smoothstep16(t);
      end
      for (int j = 0; j < 2; j++) begin
        cz = lat_cell[2] + j;
        y0 = lerp16(lattice_corner(lat_cell[0], lat_cell[1], cz),
                    lattice_corner(lat_cell[0] + 1, lat_cell[1], cz), smooth[0]);
        y1 = lerp16(lattice_corner(lat_cell[0], lat_cell[1] + 1, cz),
                    lattice_corner(lat_cell[0] + 1, lat_cell[1] + 1, cz), smooth[0]);
        zl[j] = lerp16(y0, y1, smooth[1]);
      end
      noise = lerp16(zl[0], zl[1], smooth[2]);
      octave_sum += (amp * noise) >> 30;
      norm += amp;
      amp = (amp * 18 + 12) / 25;
      freq = (freq * 13 + 2) / 5;
    end
    recip = (norm != 0) ? ((64'd1 << 60) / norm) : 64'd0;
    v = (octave_sum * recip) >> 30;
    u = longint'(v) - (longint'(1) << 31);
    prod = u * longint'({48'd0, relief});
    if (prod >= 0) h = prod >>> 16;
    else h = -(((-prod) + 65535) >>> 16);
    if (h > 64'sd2147483647) h = 64'sd2147483647;
    if (h < -64'sd2147483648) h = -64'sd2147483648;
    return h[31:0];
  endfunction

  // Clock and the single reset pulse.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
  end

  // Timeout guard.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MAX_CYCLES) begin
      $display("fractal_value_noise_height_test NOT OK");
      $finish;
    end
  end

  // Result side: random stalls, and every accepted height item is compared
  // with the oldest owed height.
  always @(posedge clk) begin
    height_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    if (!rst && height_ch.valid && height_ch.ready) begin
      if (height_queue.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected height item %0d at cycle %0d", height_ch.height_out,
                   cycle_count);
      end else begin
        if (height_ch.height_out !== height_queue[0]) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("height mismatch at cycle %0d: expected %0d, got %0d", cycle_count,
                     height_queue[0], height_ch.height_out);
        end
        void'(height_queue.pop_front());
      end
    end
  end

  // Offers one direction item, idling at random first, and records the owed
  // height once the block takes it.
  task automatic send_dir(dir_t d);
    while ($urandom_range(99) < send_idle_pct) begin
      dir_ch.valid <= 1'b0;
      @(posedge clk);
    end
    dir_ch.valid <= 1'b1;
    dir_ch.dir_x <= d.x;
    dir_ch.dir_y <= d.y;
    dir_ch.dir_z <= d.z;
    @(posedge clk);
    while (!dir_ch.ready) @(posedge clk);
    height_queue.insert(height_queue.size(), terrain_height(d, relief_now));
  endtask

  // Stops sending and waits until every owed height has come back, then lets
  // the pipeline settle.
  task automatic drain;
    dir_ch.valid <= 1'b0;
    @(posedge clk);
    while (height_queue.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_relief(logic [15:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.relief_range <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    relief_now = value;
  endtask

  // Random direction: mostly near-unit vectors with random content, some raw
  // 32-bit patterns so every bit toggles, some values near zero and a few range ends.
  function automatic logic signed [31:0] rand_axis(int unsigned kind);
    case (kind)
      0, 1, 2, 3, 4, 5: begin
        return $signed($urandom_range(32'h80000000, 0)) - 32'sh40000000;
      end
      6, 7: begin
        return $signed($urandom);
      end
      8: begin
        return $signed($urandom_range(4095, 0)) - 32'sd2048;
      end
      default: begin
        case ($urandom_range(3))
          0: return 32'sh40000000;
          1: return 32'shC0000000;
          2: return 32'sh7FFFFFFF;
          default: return 32'sh80000000;
        endcase
      end
    endcase
  endfunction

  task automatic random_phase(int unsigned count, int unsigned idle, int unsigned stall,
                              bit pause_midway);
    dir_t d;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int n = 0; n < count; n++) begin
      // Runs of no idling at all on either side inside every phase.
      if (n % 100 == 50) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end else if (n % 100 == 80) begin
        send_idle_pct = idle;
        recv_stall_pct = stall;
      end
      // Hold the sender until the block has handed back everything it owes.
      if (pause_midway && n == count / 2) drain;
      d.x = rand_axis($urandom_range(9));
      d.y = rand_axis($urandom_range(9));
      d.z = rand_axis($urandom_range(9));
      send_dir(d);
    end
  endtask

  initial begin
    cycle_count = 0;
    mismatch_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    relief_now = fvn_pkg::RELIEF_RESET;
    cfg_ch.valid = 1'b0;
    cfg_ch.relief_range = '0;
    dir_ch.valid = 1'b0;
    dir_ch.dir_x = '0;
    dir_ch.dir_y = '0;
    dir_ch.dir_z = '0;
    height_ch.ready = 1'b0;
    @(negedge rst);
    @(posedge clk);

    // Directed part at the reset relief, checked by the predictor.
    for (int r = 0; r < DIR_ROWS; r++) send_dir(DIR_TABLE[r]);
    drain;

    // With no relief every height is plainly zero, so the table is replayed
    // with that value typed in place of the predicted one.
    write_relief(16'd0);
    for (int r = 0; r < DIR_ROWS; r++) begin
      send_dir(DIR_TABLE[r]);
      height_queue[height_queue.size() - 1] = 32'sd0;
    end
    drain;

    // Random part: one phase per relief setting and idling mode.
    write_relief(16'd65535);
    random_phase(RAND_PER_PHASE, 0, 0, 1'b1);
    drain;
    write_relief(16'($urandom_range(65535)));
    random_phase(RAND_PER_PHASE, 45, 0, 1'b0);
    drain;
    write_relief(16'd1);
    random_phase(RAND_PER_PHASE, 0, 45, 1'b0);
    drain;
    write_relief(16'd1000);
    random_phase(RAND_PER_PHASE, 33, 33, 1'b0);
    drain;
    write_relief(16'($urandom_range(65535)));
    random_phase(RAND_PER_PHASE, 45, 45, 1'b0);
    drain;

    if (mismatch_count == 0 && height_queue.size() == 0) begin
      $display("fractal_value_noise_height_test OK");
    end else begin
      $display("fractal_value_noise_height_test NOT OK");
    end
    $finish;
  end

endmodule

// ===== fractal_value_noise_height.f =====
rtl/core/fvn_pkg.sv
rtl/core/fvn_if.sv
rtl/core/fvn_octave_cell.sv
rtl/core/fvn_out_stage.sv
rtl/core/fractal_value_noise_height.sv
tb/sv/fractal_value_noise_height_test.sv
